// ===== hw/rtl/sliding_window_vibration_rms_unit_macros.svh =====
// Assertion macros for the vibration RMS unit top level.
`ifndef SLIDING_WINDOW_VIBRATION_RMS_UNIT_MACROS_SVH
`define SLIDING_WINDOW_VIBRATION_RMS_UNIT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define SWVR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define SWVR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== hw/rtl/swvr_pkg.sv =====
// Shared types and constants of the vibration RMS unit.
package swvr_pkg;

   localparam int DATA_W     = 16;   // sample and result field width
   localparam int MAG_W      = 16;   // magnitude of a 16-bit signed value
   localparam int DIGIT_W    = 4;    // multiplier digit per squaring step
   localparam int DIG_CNT_W  = 2;    // counts MAG_W / DIGIT_W digits
   localparam int DIGITS     = MAG_W / DIGIT_W;
   localparam int SQ_W       = 31;   // square of a magnitude up to 2^15
   localparam int NUM_OPS    = 6;    // three old values, three new values
   localparam int OLD_OPS    = 3;
   localparam int OP_CNT_W   = 3;
   localparam int OFS_W      = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OFS_W-1:0] GRAVITY_RESET = 15'd2509;

   // Register selects, taken from paddr bit 2.
   localparam logic REG_SENSOR_PRESENT = 1'b0;
   localparam logic REG_GRAVITY_OFFSET = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } sample_type;

   typedef struct packed {
      logic busy;
      logic done;
   } swvr_ds_status_type;

   function automatic logic [MAG_W-1:0] magnitude(input logic signed [DATA_W-1:0] v);
      logic [MAG_W-1:0] u;
      u = MAG_W'(v);
      return v[DATA_W-1] ? MAG_W'(~u + 1'b1) : u;
   endfunction

endpackage

// ===== hw/rtl/swvr_chan_if.sv =====
// Valid/ready channel interfaces for sample transactions and result transactions.
interface swvr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic               read_ok;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   output read_ok, input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   input read_ok, output ready);
endinterface

interface swvr_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] rms_level;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_z;
   logic               used_default;

   modport source (output valid, output rms_level, output out_x, output out_y,
                   output out_z, output used_default, input ready);
   modport sink   (input valid, input rms_level, input out_x, input out_y,
                   input out_z, input used_default, output ready);
endinterface

// ===== hw/rtl/swvr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swvr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 20,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/swvr_divsqrt.sv =====
// Bit-serial divide by a constant followed by a two-bit-per-step integer square root.
module swvr_divsqrt import swvr_pkg::*; #(
   parameter int SUM_W   = 37,
   parameter int DIVISOR = 60,
   localparam int ROOT_W = (SUM_W + 1) / 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   output swvr_ds_status_type stat,
   output logic [ROOT_W-1:0]  root
);

   localparam int D_W    = $clog2(DIVISOR + 1);
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int CNT_W  = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} ds_state_type;

   ds_state_type        state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    num_ff, num_in;
   logic [D_W-1:0]      drem_ff, drem_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W+1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic                done_ff, done_in;

   logic [D_W:0]        dtrial;
   logic                dge;
   logic [ROOT_W+1:0]   scur;
   logic [ROOT_W+1:0]   strial;
   logic                sge;

   always_comb begin
      dtrial = {drem_ff, num_ff[SUM_W-1]};
      dge    = dtrial >= (D_W + 1)'(DIVISOR);
      scur   = {srem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
      strial = {root_ff, 2'b01};
      sge    = scur >= strial;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      drem_in  = drem_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               num_in   = dividend;
               drem_in  = '0;
               cnt_in   = CNT_W'(SUM_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring step: quotient bits shift in where dividend bits leave
            drem_in = dge ? D_W'(dtrial - (D_W + 1)'(DIVISOR)) : D_W'(dtrial);
            num_in  = {num_ff[SUM_W-2:0], dge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rad_in   = RAD_W'(num_in);
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = CNT_W'(ROOT_W - 1);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            srem_in = sge ? (scur - strial) : scur;
            root_in = {root_ff[ROOT_W-2:0], sge};
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      drem_ff <= drem_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

// ===== hw/rtl/sliding_window_vibration_rms_unit.sv =====
// Three-axis moving-window vibration RMS unit: top level.
//
// One transaction on req_bus carries an X/Y/Z accelerometer sample in signed
// 1/256 m/s^2 steps and a read-ok flag; each produces exactly one transaction
// on rsp_bus. With the sensor marked present and the read good, Z is reduced
// by gravity_offset (saturated at -32768), the corrected sample replaces the
// oldest of WINDOW ring entries, and rms_level is floor(sqrt(floor(S/(3*WINDOW))))
// where S is the sum of squares of every value in the ring. out_x/y/z echo the
// raw sample. Otherwise the ring is left alone and the defaults 0, 0, 0 and
// gravity_offset come back with used_default set. A measured transaction
// passes through the 16x4 digit squarer, which updates the running sum for
// three old and three new values, then the divider at one quotient bit per
// cycle and the square root at one root bit per cycle. The ring sits in a
// RAM; per-entry valid bits cleared by reset make unwritten entries read as
// zero, so there is no clearing pass after reset.
// req_bus is ready whenever the datapath is idle, even while a result still
// waits in the output register. Registers sit on an APB-style port: offset 0
// is sensor_present (reset 0), offset 4 gravity_offset (reset 2509); writes
// belong to quiet periods only.
module sliding_window_vibration_rms_unit import swvr_pkg::*; #(
   parameter int WINDOW = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   swvr_req_if.sink              req_bus,
   swvr_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

`include "sliding_window_vibration_rms_unit_macros.svh"

   localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int DIVISOR = 3 * WINDOW;
   localparam int SUM_W   = SQ_W + $clog2(DIVISOR);
   localparam int ROOT_W  = (SUM_W + 1) / 2;
   localparam int SMP_W   = $bits(sample_type);

   localparam logic signed [DATA_W+1:0] Z_FLOOR = -18'sd32768;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_SQ, S_ACC, S_DIV, S_DONE
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [WINDOW-1:0]      valid_ff, valid_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   start_ff, start_in;
   logic                   present_ff, present_in;
   logic [OFS_W-1:0]       grav_ff, grav_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [MAG_W-1:0]       ops_ff [NUM_OPS];
   logic [MAG_W-1:0]       ops_in [NUM_OPS];
   logic [MAG_W-1:0]       mult_ff, mult_in;
   logic [SQ_W-1:0]        acc_ff, acc_in;
   logic [OP_CNT_W-1:0]    op_cnt_ff, op_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   sample_type             new_ff, new_in;
   logic [DATA_W-1:0]      rms_ff, rms_in;
   logic signed [DATA_W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic                   dflt_ff, dflt_in;

   // result register
   logic [DATA_W-1:0]      rsp_rms_ff, rsp_rms_in;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic                   rsp_dflt_ff, rsp_dflt_in;

   // helpers
   logic                   req_take;
   logic                   csr_wr;
   logic                   use_default;
   logic signed [DATA_W+1:0] z_diff;
   logic signed [DATA_W-1:0] z_corr;
   sample_type             old_smp;
   logic [SMP_W-1:0]       ram_rdata;
   logic                   ram_we;
   logic [MAG_W+DIGIT_W-1:0] prod;
   logic [SUM_W-1:0]       sq_ext;
   logic                   out_free;
   swvr_ds_status_type     ds_stat;
   logic [ROOT_W-1:0]      ds_root;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_wr        = psel && penable && pwrite && pready;
   assign pready        = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign ram_we        = (state_ff == S_LOAD);

   always_comb begin
      unique case (paddr[2])
         REG_SENSOR_PRESENT: prdata = CSR_DATA_W'(present_ff);
         REG_GRAVITY_OFFSET: prdata = CSR_DATA_W'(grav_ff);
         default:            prdata = '0;
      endcase
   end

   swvr_ram #(.WIDTH(SMP_W), .DEPTH(WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (new_ff),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   swvr_divsqrt #(.SUM_W(SUM_W), .DIVISOR(DIVISOR)) u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (sum_ff),
      .stat     (ds_stat),
      .root     (ds_root)
   );

   always_comb begin
      use_default = !present_ff || !req_bus.read_ok;
      z_diff = $signed({{2{req_bus.accel_z[DATA_W-1]}}, req_bus.accel_z})
               - $signed({3'b000, grav_ff});
      z_corr = (z_diff < Z_FLOOR) ? DATA_W'(Z_FLOOR) : DATA_W'(z_diff);

      // an entry never written since reset reads as zero
      old_smp = valid_ff[pos_ff] ? sample_type'(ram_rdata) : '0;
      prod    = ops_ff[0] * mult_ff[MAG_W-1 -: DIGIT_W];
      sq_ext  = SUM_W'(acc_ff);

      state_in     = state_ff;
      pos_in       = pos_ff;
      valid_in     = valid_ff;
      sum_in       = sum_ff;
      start_in     = 1'b0;
      present_in   = present_ff;
      grav_in      = grav_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ops_in       = ops_ff;
      mult_in      = mult_ff;
      acc_in       = acc_ff;
      op_cnt_in    = op_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      new_in       = new_ff;
      rms_in       = rms_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      dflt_in      = dflt_ff;
      rsp_rms_in   = rsp_rms_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_dflt_in  = rsp_dflt_ff;

      if (csr_wr) begin
         unique case (paddr[2])
            REG_SENSOR_PRESENT: present_in = pwdata[0];
            REG_GRAVITY_OFFSET: grav_in    = pwdata[OFS_W-1:0];
            default:            present_in = present_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               dflt_in  = use_default;
               new_in   = '{x: req_bus.accel_x, y: req_bus.accel_y, z: z_corr};
               if (use_default) begin
                  px_in    = '0;
                  py_in    = '0;
                  pz_in    = DATA_W'(grav_ff);
                  rms_in   = '0;
                  state_in = S_DONE;
               end else begin
                  px_in    = req_bus.accel_x;
                  py_in    = req_bus.accel_y;
                  pz_in    = req_bus.accel_z;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            // overwrite the oldest entry; queue old values then new values
            ops_in[0]        = magnitude(old_smp.x);
            ops_in[1]        = magnitude(old_smp.y);
            ops_in[2]        = magnitude(old_smp.z);
            ops_in[3]        = magnitude(new_ff.x);
            ops_in[4]        = magnitude(new_ff.y);
            ops_in[5]        = magnitude(new_ff.z);
            mult_in          = magnitude(old_smp.x);
            acc_in           = '0;
            op_cnt_in        = '0;
            dig_cnt_in       = '0;
            valid_in[pos_ff] = 1'b1;
            pos_in           = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
            state_in         = S_SQ;
         end
         S_SQ: begin
            // one multiplier digit per cycle, most significant first
            acc_in     = (acc_ff << DIGIT_W) + SQ_W'(prod);
            mult_in    = mult_ff << DIGIT_W;
            dig_cnt_in = dig_cnt_ff + 1'b1;
            if (dig_cnt_ff == DIG_CNT_W'(DIGITS - 1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            // drop old squares, add new ones
            sum_in = (op_cnt_ff < OP_CNT_W'(OLD_OPS)) ? sum_ff - sq_ext : sum_ff + sq_ext;
            for (int i = 0; i < NUM_OPS - 1; i++) begin
               ops_in[i] = ops_ff[i+1];
            end
            ops_in[NUM_OPS-1] = '0;
            mult_in    = ops_ff[1];
            acc_in     = '0;
            dig_cnt_in = '0;
            op_cnt_in  = op_cnt_ff + 1'b1;
            if (op_cnt_ff == OP_CNT_W'(NUM_OPS - 1)) begin
               start_in = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_SQ;
            end
         end
         S_DIV: begin
            if (ds_stat.done) begin
               rms_in   = DATA_W'(ds_root);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rms_in   = rms_ff;
               rsp_x_in     = px_ff;
               rsp_y_in     = py_ff;
               rsp_z_in     = pz_ff;
               rsp_dflt_in  = dflt_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         valid_ff     <= '0;
         sum_ff       <= '0;
         start_ff     <= 1'b0;
         present_ff   <= 1'b0;
         grav_ff      <= GRAVITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         valid_ff     <= valid_in;
         sum_ff       <= sum_in;
         start_ff     <= start_in;
         present_ff   <= present_in;
         grav_ff      <= grav_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ops_ff      <= ops_in;
      mult_ff     <= mult_in;
      acc_ff      <= acc_in;
      op_cnt_ff   <= op_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      new_ff      <= new_in;
      rms_ff      <= rms_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      dflt_ff     <= dflt_in;
      rsp_rms_ff  <= rsp_rms_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_dflt_ff <= rsp_dflt_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.rms_level    = rsp_rms_ff;
   assign rsp_bus.out_x        = rsp_x_ff;
   assign rsp_bus.out_y        = rsp_y_ff;
   assign rsp_bus.out_z        = rsp_z_ff;
   assign rsp_bus.used_default = rsp_dflt_ff;

   `SWVR_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_W'(WINDOW - 1))
   `SWVR_ASSERT_IMP(a_dflt_rms_zero, clock, reset, rsp_valid_ff && rsp_dflt_ff, rsp_rms_ff == '0)
   `SWVR_ASSERT_IMP(a_ds_busy_in_div, clock, reset, ds_stat.busy, state_ff == S_DIV)
   `SWVR_ASSERT_IMP(a_ds_done_in_div, clock, reset, ds_stat.done, state_ff == S_DIV)
   `SWVR_ASSERT_NXT(a_load_marks_valid, clock, reset, state_ff == S_LOAD, valid_ff[$past(pos_ff)])

endmodule
